// ----- rtl/core/sdmu_pkg.sv -----
// Shared types and constants for the signed divider multimode unit.
package sdmu_pkg;

  localparam int unsigned DataW = 64;

  typedef enum logic [1:0] {
    MODE_32_32   = 2'd0,
    MODE_64_32   = 2'd1,
    MODE_64_64   = 2'd2,
    MODE_64_32_B = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [DataW-1:0] numerator;
    logic signed [DataW-1:0] denominator;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] quotient_bits;
    logic [DataW-1:0] remainder_bits;
    logic             divide_by_zero;
  } rsp_t;

  // Per-item control that rides beside the divider datapath.
  typedef struct packed {
    logic             special;
    logic [DataW-1:0] special_q;
    logic [DataW-1:0] special_r;
    logic             neg_q;
    logic             neg_r;
    logic             dz_flag;
  } ctl_t;

  localparam logic [DataW-1:0] ZeroQ32Pos = 64'h0000_0000_FFFF_FFFF;
  localparam logic [DataW-1:0] ZeroQ32Neg = 64'hFFFF_FFFF_0000_0001;
  localparam logic [DataW-1:0] OvfQ32     = 64'h0000_0000_8000_0000;
  localparam logic [DataW-1:0] Min64      = 64'h8000_0000_0000_0000;
  localparam logic [DataW-1:0] AllOnes    = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

// ----- rtl/core/sdmu_prep.sv -----
// Front stage: operand selection, special cases and magnitudes.
module sdmu_prep (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  sdmu_pkg::mode_t              mode,
  input  sdmu_pkg::req_t               req,
  output logic                         out_valid,
  output logic [sdmu_pkg::DataW-1:0]   mag_n,
  output logic [sdmu_pkg::DataW-1:0]   mag_d,
  output sdmu_pkg::ctl_t               ctl
);

  logic [sdmu_pkg::DataW-1:0] n, d;
  logic                       neg_n, neg_d, d_zero, ovf;
  sdmu_pkg::ctl_t             ctl_next;

  // Select operands for the mode and detect the special cases.
  always_comb begin
    if (mode == sdmu_pkg::MODE_32_32) begin
      n = {{32{req.numerator[31]}}, req.numerator[31:0]};
    end else begin
      n = req.numerator;
    end
    if (mode == sdmu_pkg::MODE_64_64) begin
      d = req.denominator;
    end else begin
      d = {{32{req.denominator[31]}}, req.denominator[31:0]};
    end
    neg_n  = n[63];
    neg_d  = d[63];
    d_zero = (d == '0);
    ovf    = (d == sdmu_pkg::AllOnes) && (n == sdmu_pkg::Min64);
    ctl_next           = '0;
    ctl_next.neg_q     = neg_n ^ neg_d;
    ctl_next.neg_r     = neg_n;
    ctl_next.dz_flag   = (req.denominator == '0);
    ctl_next.special   = d_zero || ovf;
    if (d_zero) begin
      ctl_next.special_r = n;
      if (mode == sdmu_pkg::MODE_32_32) begin
        ctl_next.special_q = neg_n ? sdmu_pkg::ZeroQ32Neg : sdmu_pkg::ZeroQ32Pos;
      end else begin
        ctl_next.special_q = neg_n ? 64'd1 : sdmu_pkg::AllOnes;
      end
    end else begin
      ctl_next.special_r = '0;
      ctl_next.special_q = (mode == sdmu_pkg::MODE_32_32) ? sdmu_pkg::OvfQ32
                                                           : sdmu_pkg::Min64;
    end
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (en) begin
      mag_n <= neg_n ? (64'd0 - n) : n;
      mag_d <= neg_d ? (64'd0 - d) : d;
      ctl   <= ctl_next;
    end
  end

endmodule

// ----- rtl/core/sdmu_stage.sv -----
// One restoring division stage that retires BitsPerStage quotient bits.
module sdmu_stage #(
  parameter int unsigned BitsPerStage = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [sdmu_pkg::DataW-1:0]   in_n,
  input  logic [sdmu_pkg::DataW-1:0]   in_d,
  input  logic [sdmu_pkg::DataW-1:0]   in_r,
  input  sdmu_pkg::ctl_t               in_ctl,
  output logic                         out_valid,
  output logic [sdmu_pkg::DataW-1:0]   out_n,
  output logic [sdmu_pkg::DataW-1:0]   out_d,
  output logic [sdmu_pkg::DataW-1:0]   out_r,
  output sdmu_pkg::ctl_t               out_ctl
);

  // n shifts out high bits as it fills with quotient bits from the bottom.
  logic [sdmu_pkg::DataW-1:0] n_w [BitsPerStage+1];
  logic [sdmu_pkg::DataW:0]   r_w [BitsPerStage+1];
  logic [sdmu_pkg::DataW:0]   sh;

  always_comb begin
    n_w[0] = in_n;
    r_w[0] = {1'b0, in_r};
    sh     = '0;
    for (int i = 0; i < BitsPerStage; i++) begin
      sh = {r_w[i][sdmu_pkg::DataW-1:0], n_w[i][sdmu_pkg::DataW-1]};
      if (sh >= {1'b0, in_d}) begin
        r_w[i+1] = sh - {1'b0, in_d};
        n_w[i+1] = {n_w[i][sdmu_pkg::DataW-2:0], 1'b1};
      end else begin
        r_w[i+1] = sh;
        n_w[i+1] = {n_w[i][sdmu_pkg::DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_n   <= n_w[BitsPerStage];
      out_d   <= in_d;
      out_r   <= r_w[BitsPerStage][sdmu_pkg::DataW-1:0];
      out_ctl <= in_ctl;
    end
  end

endmodule

// ----- rtl/core/sdmu_post.sv -----
// Back stage: sign fix-up, special-case select and output register.
module sdmu_post (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [sdmu_pkg::DataW-1:0]   mag_q,
  input  logic [sdmu_pkg::DataW-1:0]   mag_r,
  input  sdmu_pkg::ctl_t               ctl,
  output logic                         out_valid,
  output sdmu_pkg::rsp_t               rsp
);

  sdmu_pkg::rsp_t rsp_next;

  // Apply signs, or substitute the fixed answer of a special case.
  always_comb begin
    rsp_next.divide_by_zero = ctl.dz_flag;
    if (ctl.special) begin
      rsp_next.quotient_bits  = ctl.special_q;
      rsp_next.remainder_bits = ctl.special_r;
    end else begin
      rsp_next.quotient_bits  = ctl.neg_q ? (64'd0 - mag_q) : mag_q;
      rsp_next.remainder_bits = ctl.neg_r ? (64'd0 - mag_r) : mag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- rtl/core/signed_divider_multimode_unit.sv -----
// Top level of the pipelined signed divider with selectable operand widths.
// Usage:
//   Requests enter on in_valid/in_ready carrying a req_t beat (numerator and
//   denominator); results leave on out_valid/out_ready as an rsp_t beat.
//   The operating mode is written through mode_we/mode_data while the unit is
//   idle: 0 divides 32 by 32, 1 or 3 divide 64 by 32, 2 divides 64 by 64.
// Path: a result passes through the prep register, the chain of restoring
//   stages and the output register on its way from acceptance to out_valid.
// Throughput: one beat per cycle while no result beat waits with out_ready
//   low; the pipe holds one item per stage.
// Stalls: the whole pipe advances only while the output register is empty
//   or being drained, so while a result beat waits with out_ready low every
//   stage holds its beat and in_ready is low, whether or not the pipe is
//   full; nothing is lost or repeated.
// Reset: rst, synchronous and active high, empties every stage and sets the
//   mode to 32 by 32.
module signed_divider_multimode_unit #(
  parameter int unsigned BitsPerStage = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             mode_we,
  input  logic [1:0]       mode_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdmu_pkg::req_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sdmu_pkg::rsp_t   out_data
);

  localparam int unsigned Stages = sdmu_pkg::DataW / BitsPerStage;

  sdmu_pkg::mode_t mode;
  logic            en;

  logic                       v   [Stages+1];
  logic [sdmu_pkg::DataW-1:0] n_s [Stages+1];
  logic [sdmu_pkg::DataW-1:0] d_s [Stages+1];
  logic [sdmu_pkg::DataW-1:0] r_s [Stages+1];
  sdmu_pkg::ctl_t             c_s [Stages+1];

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sdmu_pkg::MODE_32_32;
    end else if (mode_we) begin
      mode <= sdmu_pkg::mode_t'(mode_data);
    end
  end

  // Global advance: move when the output beat is absent or taken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  sdmu_prep u_prep (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .mode     (mode),
    .req      (in_data),
    .out_valid(v[0]),
    .mag_n    (n_s[0]),
    .mag_d    (d_s[0]),
    .ctl      (c_s[0])
  );
  assign r_s[0] = '0;

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    sdmu_stage #(.BitsPerStage(BitsPerStage)) u_stage (
      .clk, .rst, .en,
      .in_valid (v[g]),
      .in_n     (n_s[g]),
      .in_d     (d_s[g]),
      .in_r     (r_s[g]),
      .in_ctl   (c_s[g]),
      .out_valid(v[g+1]),
      .out_n    (n_s[g+1]),
      .out_d    (d_s[g+1]),
      .out_r    (r_s[g+1]),
      .out_ctl  (c_s[g+1])
    );
  end

  sdmu_post u_post (
    .clk, .rst, .en,
    .in_valid (v[Stages]),
    .mag_q    (n_s[Stages]),
    .mag_r    (r_s[Stages]),
    .ctl      (c_s[Stages]),
    .out_valid(out_valid),
    .rsp      (out_data)
  );

  // A stalled output beat holds its flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data.divide_by_zero))
    else $error("output beat changed while stalled");

  // Nothing enters while the pipe is frozen.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken during stall");

  // Front-stage valid follows an accepted beat.
  a_front: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted beat lost at front stage");

endmodule

// ----- tb/tb_signed_divider_multimode_unit.sv -----
// Self-checking testbench for the signed divider multimode unit.
module tb_signed_divider_multimode_unit;

  localparam int unsigned Latency = 18;
  localparam int unsigned CycleLimit = 400000;

  localparam logic [63:0] ZeroQ32Pos = sdmu_pkg::ZeroQ32Pos;
  localparam logic [63:0] ZeroQ32Neg = sdmu_pkg::ZeroQ32Neg;
  localparam logic [63:0] OvfQ32     = sdmu_pkg::OvfQ32;
  localparam logic [63:0] Min64      = sdmu_pkg::Min64;
  localparam logic [63:0] AllOnes    = sdmu_pkg::AllOnes;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic mode_we = 1'b0;
  logic [1:0] mode_data = sdmu_pkg::MODE_32_32;
  logic in_valid = 1'b0;
  logic in_ready;
  sdmu_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sdmu_pkg::rsp_t out_data;

  signed_divider_multimode_unit i_dut (
    .clk(clk), .rst(rst), .mode_we(mode_we), .mode_data(mode_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Results still owed by the unit, oldest first.
  sdmu_pkg::rsp_t quotient_fifo[$];
  sdmu_pkg::mode_t cur_mode = sdmu_pkg::MODE_32_32;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit quiet_phase = 1'b0;

  // Directed rows; check_q marks rows whose quotient and remainder are typed in.
  typedef struct {
    sdmu_pkg::mode_t mode;
    logic [63:0] num;
    logic [63:0] den;
    bit check_q;
    logic [63:0] q;
    logic [63:0] r;
  } row_t;

  function automatic logic [63:0] sign_ext32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Truncating division of 64-bit patterns, remainder follows the numerator.
  function automatic void trunc_divide(logic [63:0] n, logic [63:0] d,
                                       output logic [63:0] q, output logic [63:0] r);
    logic [63:0] mn, md, mq, mr;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    mq = mn / md;
    mr = mn % md;
    q = (n[63] != d[63]) ? -mq : mq;
    r = n[63] ? -mr : mr;
  endfunction

  function automatic sdmu_pkg::rsp_t divide_predict(sdmu_pkg::mode_t m, logic [63:0] num,
                                                    logic [63:0] den);
    sdmu_pkg::rsp_t res;
    logic [63:0] n, d, q, r;
    if (m == sdmu_pkg::MODE_32_32) begin
      n = sign_ext32(num);
      d = sign_ext32(den);
      if (d == 0) begin
        r = n;
        q = n[63] ? ZeroQ32Neg : ZeroQ32Pos;
      end else if (num[31:0] == 32'h8000_0000 && d == AllOnes) begin
        q = OvfQ32;
        r = '0;
      end else begin
        trunc_divide(n, d, q, r);
      end
    end else begin
      n = num;
      d = (m == sdmu_pkg::MODE_64_64) ? den : sign_ext32(den);
      if (d == 0) begin
        r = n;
        q = n[63] ? 64'd1 : AllOnes;
      end else if (n == Min64 && d == AllOnes) begin
        q = Min64;
        r = '0;
      end else begin
        trunc_divide(n, d, q, r);
      end
    end
    res.quotient_bits = q;
    res.remainder_bits = r;
    res.divide_by_zero = (den == 0);
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operands biased toward small magnitudes so that quotients are non-trivial.
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = rand64();
      1: v = sign_ext32({32'd0, $urandom()});
      2: v = 64'($urandom_range(0, 20)) - 64'd10;
      3: v = rand64() >> $urandom_range(0, 63);
      4: v = {$urandom(), 32'd0} | 64'($urandom_range(0, 3));
      default: v = -(rand64() >> $urandom_range(1, 63));
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: compare each beat against the oldest expectation.
  always @(posedge clk) begin
    sdmu_pkg::rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (quotient_fifo.size() == 0) begin
        $error("unexpected result beat q=%h", out_data.quotient_bits);
        errors++;
      end else begin
        want = quotient_fifo.pop_front();
        if (out_data.quotient_bits !== want.quotient_bits) begin
          $error("quotient_bits: expected %h, actual %h",
                 want.quotient_bits, out_data.quotient_bits);
          errors++;
        end
        if (out_data.remainder_bits !== want.remainder_bits) begin
          $error("remainder_bits: expected %h, actual %h",
                 want.remainder_bits, out_data.remainder_bits);
          errors++;
        end
        if (out_data.divide_by_zero !== want.divide_by_zero) begin
          $error("divide_by_zero: expected %b, actual %b",
                 want.divide_by_zero, out_data.divide_by_zero);
          errors++;
        end
      end
    end
  end

  // Receiver stalls, switched off during the quiet phase.
  always @(negedge clk) begin
    out_ready <= quiet_phase ? 1'b1 : ($urandom_range(0, 99) >= 13);
  end

  // Drops the request line and waits until every owed result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (quotient_fifo.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  task automatic write_mode(sdmu_pkg::mode_t m);
    wait_drained();
    mode_we <= 1'b1;
    mode_data <= m;
    @(negedge clk);
    mode_we <= 1'b0;
    cur_mode = m;
  endtask

  // Sends one beat, holding valid until it is accepted, then maybe a gap.
  task automatic send_division(logic [63:0] num, logic [63:0] den);
    in_valid <= 1'b1;
    in_data.numerator <= num;
    in_data.denominator <= den;
    do @(posedge clk); while (!in_ready);
    quotient_fifo.push_back(divide_predict(cur_mode, num, den));
    @(negedge clk);
    if (!quiet_phase && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  row_t rows[$];
  sdmu_pkg::mode_t rmode;

  initial begin
    // Extremes, zero divisors and overflow cases in every mode.
    rows = '{
      '{sdmu_pkg::MODE_32_32, 64'd7, 64'd2, 1, 64'd3, 64'd1},
      '{sdmu_pkg::MODE_32_32, 64'd5, 64'd0, 1, ZeroQ32Pos, 64'd5},
      '{sdmu_pkg::MODE_32_32, -64'd5, 64'd0, 1, ZeroQ32Neg, -64'd5},
      '{sdmu_pkg::MODE_32_32, 64'h1234_5678_8000_0000, AllOnes, 1, OvfQ32, 64'd0},
      '{sdmu_pkg::MODE_32_32, 64'd9, 64'h1_0000_0000, 1, ZeroQ32Pos, 64'd9},
      '{sdmu_pkg::MODE_32_32, -64'd7, 64'd2, 1, -64'd3, -64'd1},
      '{sdmu_pkg::MODE_32_32, 64'h7FFF_FFFF, 64'h8000_0000, 0, 0, 0},
      '{sdmu_pkg::MODE_64_32, Min64, AllOnes, 1, Min64, 64'd0},
      '{sdmu_pkg::MODE_64_32, 64'd5, 64'd0, 1, AllOnes, 64'd5},
      '{sdmu_pkg::MODE_64_32, -64'd5, 64'h5_0000_0000, 1, 64'd1, -64'd5},
      '{sdmu_pkg::MODE_64_32, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000, 0, 0, 0},
      '{sdmu_pkg::MODE_64_32, Min64, 64'hFFFF_FFFF, 1, Min64, 64'd0},
      '{sdmu_pkg::MODE_64_64, Min64, AllOnes, 1, Min64, 64'd0},
      '{sdmu_pkg::MODE_64_64, 64'd5, 64'h5_0000_0000, 1, 64'd0, 64'd5},
      '{sdmu_pkg::MODE_64_64, -64'd1, 64'd0, 1, 64'd1, AllOnes},
      '{sdmu_pkg::MODE_64_64, 64'h7FFF_FFFF_FFFF_FFFF, Min64, 0, 0, 0},
      '{sdmu_pkg::MODE_64_64, Min64, 64'd3, 0, 0, 0},
      '{sdmu_pkg::MODE_64_32_B, Min64, AllOnes, 1, Min64, 64'd0},
      '{sdmu_pkg::MODE_64_32_B, 64'd100, -64'd7, 1, -64'd14, 64'd2},
      '{sdmu_pkg::MODE_64_32_B, 64'd3, 64'hFFFF_FFFF_0000_0000, 1, AllOnes, 64'd3}
    };
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].mode != cur_mode) write_mode(rows[i].mode);
      if (rows[i].check_q) begin
        if (divide_predict(rows[i].mode, rows[i].num, rows[i].den).quotient_bits
            !== rows[i].q ||
            divide_predict(rows[i].mode, rows[i].num, rows[i].den).remainder_bits
            !== rows[i].r) begin
          $error("directed row %0d: predictor disagrees with table", i);
          errors++;
        end
      end
      send_division(rows[i].num, rows[i].den);
    end

    // Random phases across all modes; one phase runs with no stalls at all.
    for (int ph = 0; ph < 8; ph++) begin
      rmode = sdmu_pkg::mode_t'(ph % 4);
      write_mode(rmode);
      quiet_phase = (ph == 5);
      for (int k = 0; k < 66; k++) begin
        send_division(rand_operand(), ($urandom_range(0, 15) == 0) ? 64'd0
                                                                   : rand_operand());
        // Sender holds off until the unit has drained.
        if (ph == 2 && k == 30) begin
          in_valid <= 1'b0;
          wait_drained();
        end
      end
      quiet_phase = 1'b0;
    end
    in_valid <= 1'b0;

    wait_drained();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sdmu_pkg.sv
rtl/core/sdmu_prep.sv
rtl/core/sdmu_stage.sv
rtl/core/sdmu_post.sv
rtl/core/signed_divider_multimode_unit.sv
tb/tb_signed_divider_multimode_unit.sv
